// ----- hdl/lcs_length_engine_core_assert.svh -----
// Assertion helpers for the RTL that checks itself.
`ifndef LCS_LENGTH_ENGINE_CORE_ASSERT_SVH
`define LCS_LENGTH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define LCS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("lcs_length_engine_core: same-cycle check failed");

// Next-cycle implication, idle during reset.
`define LCS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("lcs_length_engine_core: next-cycle check failed");

`endif

// ----- hdl/lcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_in;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcs_length;
    logic       overflow_flag;
  } out_item_t;

  localparam logic REQ_A = 1'b0;
  localparam logic REQ_B = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic row;
    logic col;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic last_col;
    logic rows_done;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/lcs_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lcs_in_if;
  logic             valid;
  logic             ready;
  lcs_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/lcs_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lcs_out_if;
  logic              valid;
  logic              ready;
  lcs_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hdl/lcs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  lcs_pkg::in_item_t   in_item,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  lcs_pkg::dp_status_t status,
  output lcs_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_ROW,
    ST_CELL,
    ST_DRAIN,
    ST_FIN
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_LOAD);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == ST_LOAD) && in_valid;
    cmd.start  = (state == ST_START);
    cmd.row    = (state == ST_ROW);
    cmd.col    = (state == ST_CELL);
    cmd.finish = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_valid && (in_item.req_type == lcs_pkg::REQ_B) && in_item.last_char) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          if (status.a_zero || status.b_zero) begin
            state <= ST_FIN;
          end else begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          state <= ST_CELL;
        end
        ST_CELL: begin
          if (status.last_col) begin
            state <= status.rows_done ? ST_DRAIN : ST_ROW;
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lcs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcs_datapath #(
  parameter int MAX_LEN = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  lcs_pkg::in_item_t   in_item,
  input  lcs_pkg::dp_cmd_t    cmd,
  output lcs_pkg::dp_status_t status,
  output lcs_pkg::out_item_t  result
);

  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int RW = (CW > 8) ? CW : 8;

  logic [7:0]    a_mem [MAX_LEN];
  logic [7:0]    b_mem [MAX_LEN];
  logic [CW-1:0] dp_mem [MAX_LEN];

  logic [CW-1:0] a_count;
  logic [CW-1:0] b_count;
  logic          truncated;
  logic [CW-1:0] ri;
  logic [IW-1:0] jc;
  logic          p_valid;
  logic [IW-1:0] p_addr;
  logic          first_row;

  logic [7:0]    a_q;
  logic [7:0]    b_q;
  logic [CW-1:0] dp_q;
  logic [CW-1:0] left;
  logic [CW-1:0] diag;

  logic          a_room;
  logic          b_room;
  logic          load_a;
  logic          load_b;
  logic [CW-1:0] up;
  logic [CW-1:0] cell_val;
  logic [RW-1:0] res_wide;

  assign a_room = (a_count < CW'(MAX_LEN));
  assign b_room = (b_count < CW'(MAX_LEN));
  assign load_a = cmd.load && (in_item.req_type == lcs_pkg::REQ_A);
  assign load_b = cmd.load && (in_item.req_type == lcs_pkg::REQ_B);

  assign status.a_zero    = (a_count == '0);
  assign status.b_zero    = (b_count == '0);
  assign status.last_col  = (CW'(jc) == (b_count - CW'(1)));
  assign status.rows_done = (ri == a_count);

  // The row memory holds nothing valid before the first row of a run, so the
  // upper neighbor reads as zero there.
  assign up       = first_row ? '0 : dp_q;
  assign cell_val = (a_q == b_q) ? (diag + CW'(1)) : ((up > left) ? up : left);
  assign res_wide = RW'(left);

  always_ff @(posedge clk) begin
    if (load_a && a_room) begin
      a_mem[a_count[IW-1:0]] <= in_item.char_in;
    end
    if (cmd.row) begin
      a_q <= a_mem[ri[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_b && b_room) begin
      b_mem[b_count[IW-1:0]] <= in_item.char_in;
    end
    if (cmd.col) begin
      b_q <= b_mem[jc];
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      dp_mem[p_addr] <= cell_val;
    end
    if (cmd.col) begin
      dp_q <= dp_mem[jc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_count   <= '0;
      b_count   <= '0;
      truncated <= 1'b0;
      ri        <= '0;
      jc        <= '0;
      p_valid   <= 1'b0;
      first_row <= 1'b0;
    end else begin
      p_valid <= cmd.col;
      if (load_a) begin
        if (a_room) begin
          a_count <= a_count + CW'(1);
        end else begin
          truncated <= 1'b1;
        end
      end
      if (load_b) begin
        if (b_room) begin
          b_count <= b_count + CW'(1);
        end else begin
          truncated <= 1'b1;
        end
      end
      if (cmd.start) begin
        ri <= '0;
      end
      if (cmd.row) begin
        ri        <= ri + CW'(1);
        jc        <= '0;
        first_row <= (ri == '0);
      end
      if (cmd.col) begin
        jc <= jc + IW'(1);
      end
      if (cmd.finish) begin
        a_count   <= '0;
        b_count   <= '0;
        truncated <= 1'b0;
      end
    end
  end

  // The last cell of a row is still written while the next row starts, but
  // the running neighbors restart from zero.
  always_ff @(posedge clk) begin
    if (cmd.col) begin
      p_addr <= jc;
    end
    if (cmd.start || cmd.row) begin
      left <= '0;
      diag <= '0;
    end else if (p_valid) begin
      left <= cell_val;
      diag <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.lcs_length    <= (res_wide > RW'(255)) ? 8'hFF : res_wide[7:0];
      result.overflow_flag <= truncated;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lcs_length_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Longest common subsequence length engine. Bytes of string A (req_type 0)
// and string B (req_type 1) are taken one per cycle; up to MAX_LEN bytes of
// each are kept and any further bytes are dropped and reported through
// overflow_flag. The transaction that carries B's last byte starts the table
// walk, and input stays blocked until the result has been placed in the
// output register. The walk computes one table cell per cycle, after a
// setup step at the start of each row, and skips the rows when either string
// is empty; its rate is bounded by the single read port of the row memory.
// Its final step repeats for as long as the previous result has not yet
// been taken. After a result both strings start empty again.
module lcs_length_engine_core #(
  parameter int MAX_LEN = 128
) (
  input logic      clk,
  input logic      rst,
  lcs_in_if.sink   in_ch,
  lcs_out_if.source out_ch
);

  `include "lcs_length_engine_core_assert.svh"

  lcs_pkg::dp_cmd_t    cmd;
  lcs_pkg::dp_status_t status;
  logic                b_last_taken;

  lcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_item   (in_ch.payload),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  lcs_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .in_item (in_ch.payload),
    .cmd     (cmd),
    .status  (status),
    .result  (out_ch.payload)
  );

  assign b_last_taken = in_ch.valid && in_ch.ready &&
                        (in_ch.payload.req_type == lcs_pkg::REQ_B) &&
                        in_ch.payload.last_char;

  `LCS_ASSERT_NXT(b_last_blocks_input, clk, rst, b_last_taken, !in_ch.ready)
  `LCS_ASSERT_IMP(single_command, clk, rst, 1'b1, $onehot0(cmd))
  `LCS_ASSERT_NXT(finish_shows_result, clk, rst, cmd.finish, out_ch.valid)
  `LCS_ASSERT_IMP(no_input_during_walk, clk, rst, cmd.row || cmd.col, !in_ch.ready)

endmodule

`default_nettype wire
